@@ src/slcd_pkg.sv @@
package slcd_pkg;

	localparam int DEF_SYNC_LEN    = 2;
	localparam int DEF_STORE_DEPTH = 64;

	// Frame layout: length (2 bytes) and header checksum follow the sync.
	localparam int HDR_TAIL     = 3;
	// Password, command and application checksum.
	localparam int APP_FIXED    = 7;
	localparam int ERR_LEN      = 4;
	localparam int MAX_RESULTS  = 64;
	localparam int MAX_APP_LEN  = MAX_RESULTS + 10;
	localparam int MIN_APP_RST  = 11;

	localparam int INQ_DEPTH    = 4;

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_APP_LEN  = 1'b1;

	localparam logic KIND_INFO = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HDR,
		ST_LEN,
		ST_APP,
		ST_INFO,
		ST_DATA
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} inq_head_t;

	typedef struct packed {
		logic idle;
		logic full;
	} core_status_t;

endpackage

@@ src/slcd_ifs.sv @@
interface slcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_res_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic [31:0] frame_password;
	logic [15:0] frame_command;
	logic [31:0] frame_error_code;
	logic [7:0]  data_byte;
	logic        last_of_frame;

	modport source (output valid, output item_kind, output frame_password,
		output frame_command, output frame_error_code, output data_byte,
		output last_of_frame, input ready);
	modport sink (input valid, input item_kind, input frame_password,
		input frame_command, input frame_error_code, input data_byte,
		input last_of_frame, output ready);
endinterface

@@ src/slcd_inq.sv @@
module slcd_inq import slcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	slcd_byte_if.sink rx,
	output inq_head_t head,
	input  logic      pop
);

	localparam int PW   = $clog2(INQ_DEPTH);
	localparam int CNTW = $clog2(INQ_DEPTH + 1);

	logic [7:0]      buf_q [INQ_DEPTH];
	logic [PW-1:0]   rp_q;
	logic [PW-1:0]   wp_q;
	logic [CNTW-1:0] cnt_q;
	logic            push;
	logic            pull;

	assign rx.ready   = cnt_q != CNTW'(INQ_DEPTH);
	assign push       = rx.valid && rx.ready;
	assign pull       = pop && (cnt_q != '0);
	assign head.valid = cnt_q != '0;
	assign head.data  = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pull) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pull) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pull && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= rx.rx_byte;
		end
	end

endmodule

@@ src/slcd_core.sv @@
module slcd_core import slcd_pkg::*; #(
	parameter int SYNC_LEN    = DEF_SYNC_LEN,
	parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  inq_head_t             inq,
	output logic                  pop,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	slcd_res_if.source            res,
	output core_status_t          status
);

	localparam int AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW       = $clog2(STORE_DEPTH + 1);
	localparam int LINK_HDR = SYNC_LEN + HDR_TAIL;
	localparam int DATA_OFF = LINK_HDR + APP_FIXED - 1 + ERR_LEN;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (s >= (CW + 1)'(STORE_DEPTH)) begin
			s = s - (CW + 1)'(STORE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	logic [31:0] sync_pattern_q;
	logic [6:0]  min_len_q;

	function automatic logic [7:0] sbyte(input int j);
		return sync_pattern_q[8*(SYNC_LEN-1-j) +: 8];
	endfunction

	state_t        state_q;
	state_t        state_n;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          fetch_q;
	logic          ovalid_q;

	logic [7:0]    mem [STORE_DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	logic [7:0]    win_q [SYNC_LEN];
	logic [7:0]    win_next [SYNC_LEN];
	logic [7:0]    sum_q;
	logic [7:0]    sum_n;
	logic [15:0]   len_q;
	logic [CW-1:0] total_q;
	logic          hok_q;
	logic [31:0]   pwd_q;
	logic [15:0]   cmd_q;
	logic [31:0]   err_q;

	logic          kind_q;
	logic [31:0]   opwd_q;
	logic [15:0]   ocmd_q;
	logic [31:0]   oerr_q;
	logic [7:0]    obyte_q;
	logic          olast_q;

	logic          avail;
	logic          out_free;
	logic          scan_done;
	logic          hit;
	logic [CW-1:0] tail_len;
	logic [CW-1:0] pos;
	logic          hdr_short;
	logic          hdr_last;
	logic          app_last;
	logic          data_last;
	logic          sum_ok;
	logic [16:0]   total_w;
	logic          len_big;
	logic          len_wait;
	logic          len_short;
	logic [6:0]    eff_min;
	logic          has_err;
	logic          biz_none;
	logic [CW-1:0] off;
	logic          load_info;
	logic          load_data;

	assign rd_addr   = wrap(head_q, idx_q);
	assign wr_addr   = wrap(head_q, count_q);
	assign avail     = !fetch_q;
	assign out_free  = !ovalid_q || res.ready;
	assign scan_done = idx_q == count_q;
	assign pos       = idx_q - CW'(SYNC_LEN - 1);
	assign hdr_short = count_q < CW'(LINK_HDR);
	assign hdr_last  = idx_q == CW'(SYNC_LEN + 2);
	assign app_last  = idx_q == total_q - CW'(1);
	assign data_last = idx_q == total_q - CW'(2);
	assign sum_n     = sum_q + rd_data_q;
	assign sum_ok    = rd_data_q == (8'd0 - sum_q);
	assign total_w   = {1'b0, len_q} + 17'(LINK_HDR);
	assign len_big   = (len_q > 16'(MAX_APP_LEN)) || (total_w > 17'(STORE_DEPTH));
	assign len_wait  = 17'(count_q) < total_w;
	assign eff_min   = (min_len_q < 7'(APP_FIXED)) ? 7'(APP_FIXED) : min_len_q;
	assign len_short = len_q < {9'd0, eff_min};
	assign has_err   = len_q >= 16'(APP_FIXED + ERR_LEN);
	assign biz_none  = len_q <= 16'(APP_FIXED + ERR_LEN);
	assign off       = idx_q - CW'(LINK_HDR);

	// The window holds the last SYNC_LEN bytes walked, newest at the top.
	always_comb begin
		for (int k = 0; k < SYNC_LEN - 1; k++) begin
			win_next[k] = win_q[k+1];
		end
		win_next[SYNC_LEN-1] = rd_data_q;
		hit = idx_q >= CW'(SYNC_LEN - 1);
		for (int k = 0; k < SYNC_LEN; k++) begin
			if (win_next[k] != sbyte(k)) begin
				hit = 1'b0;
			end
		end
	end

	// Longest tail of the store that equals a prefix of the sync; it is kept.
	always_comb begin
		logic ok;
		tail_len = '0;
		for (int t = 1; t < SYNC_LEN; t++) begin
			ok = CW'(t) <= count_q;
			for (int j = 0; j < t; j++) begin
				if (win_q[SYNC_LEN-t+j] != sbyte(j)) begin
					ok = 1'b0;
				end
			end
			if (ok) begin
				tail_len = CW'(t);
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (inq.valid) begin
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_n = ST_IDLE;
				end else if (avail && hit) begin
					state_n = ST_HDR;
				end
			end
			ST_HDR: begin
				if (hdr_short) begin
					state_n = ST_IDLE;
				end else if (avail && hdr_last) begin
					state_n = ST_LEN;
				end
			end
			ST_LEN: begin
				if (!hok_q || len_big) begin
					state_n = ST_SCAN;
				end else if (len_wait) begin
					state_n = ST_IDLE;
				end else if (len_short) begin
					state_n = ST_SCAN;
				end else begin
					state_n = ST_APP;
				end
			end
			ST_APP: begin
				if (avail && app_last) begin
					state_n = sum_ok ? ST_INFO : ST_SCAN;
				end
			end
			ST_INFO: begin
				if (out_free) begin
					state_n = biz_none ? ST_IDLE : ST_DATA;
				end
			end
			ST_DATA: begin
				if (avail && out_free && data_last) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		load_info = 1'b0;
		load_data = 1'b0;
		unique case (state_q)
			ST_IDLE: pop       = inq.valid;
			ST_INFO: load_info = out_free;
			ST_DATA: load_data = avail && out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_q         <= '0;
			count_q        <= '0;
			idx_q          <= '0;
			fetch_q        <= 1'b1;
			ovalid_q       <= 1'b0;
			sync_pattern_q <= '0;
			min_len_q      <= 7'(MIN_APP_RST);
		end else begin
			state_q <= state_n;
			fetch_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SYNC_PATTERN: sync_pattern_q <= cfg_wdata;
					REG_MIN_APP_LEN:  min_len_q      <= cfg_wdata[6:0];
					default: begin
					end
				endcase
			end
			if (load_info || load_data) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						// A full store loses its oldest byte to the new one.
						if (count_q == CW'(STORE_DEPTH)) begin
							head_q <= wrap(head_q, CW'(1));
						end else begin
							count_q <= count_q + CW'(1);
						end
						idx_q   <= '0;
						fetch_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						head_q  <= wrap(head_q, count_q - tail_len);
						count_q <= tail_len;
					end else if (avail) begin
						if (hit) begin
							head_q  <= wrap(head_q, pos);
							count_q <= count_q - pos;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
						fetch_q <= 1'b1;
					end
				end
				ST_HDR: begin
					if (avail && !hdr_short && !hdr_last) begin
						idx_q   <= idx_q + CW'(1);
						fetch_q <= 1'b1;
					end
				end
				ST_LEN: begin
					if (!hok_q || len_big) begin
						head_q  <= wrap(head_q, CW'(1));
						count_q <= count_q - CW'(1);
						idx_q   <= '0;
						fetch_q <= 1'b1;
					end else if (!len_wait) begin
						if (len_short) begin
							head_q  <= wrap(head_q, total_w[CW-1:0]);
							count_q <= count_q - total_w[CW-1:0];
							idx_q   <= '0;
						end else begin
							idx_q <= CW'(LINK_HDR);
						end
						fetch_q <= 1'b1;
					end
				end
				ST_APP: begin
					if (avail) begin
						if (app_last) begin
							if (!sum_ok) begin
								head_q  <= wrap(head_q, CW'(1));
								count_q <= count_q - CW'(1);
								idx_q   <= '0;
								fetch_q <= 1'b1;
							end
						end else begin
							idx_q   <= idx_q + CW'(1);
							fetch_q <= 1'b1;
						end
					end
				end
				ST_INFO: begin
					if (out_free) begin
						if (biz_none) begin
							head_q  <= wrap(head_q, total_q);
							count_q <= count_q - total_q;
						end else begin
							idx_q   <= CW'(DATA_OFF);
							fetch_q <= 1'b1;
						end
					end
				end
				ST_DATA: begin
					if (avail && out_free) begin
						if (data_last) begin
							head_q  <= wrap(head_q, total_q);
							count_q <= count_q - total_q;
						end else begin
							idx_q   <= idx_q + CW'(1);
							fetch_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (pop) begin
			mem[wr_addr] <= inq.data;
		end
		case (state_q)
			ST_SCAN: begin
				if (avail && !scan_done) begin
					win_q <= win_next;
				end
				sum_q <= '0;
			end
			ST_HDR: begin
				if (avail && !hdr_short) begin
					if (hdr_last) begin
						hok_q <= sum_ok;
					end else begin
						sum_q <= sum_n;
					end
					if (idx_q == CW'(SYNC_LEN)) begin
						len_q[15:8] <= rd_data_q;
					end
					if (idx_q == CW'(SYNC_LEN + 1)) begin
						len_q[7:0] <= rd_data_q;
					end
				end
			end
			ST_LEN: begin
				total_q <= total_w[CW-1:0];
				sum_q   <= '0;
			end
			ST_APP: begin
				if (avail && !app_last) begin
					sum_q <= sum_n;
					if (off < CW'(4)) begin
						pwd_q <= {pwd_q[23:0], rd_data_q};
					end else if (off < CW'(6)) begin
						cmd_q <= {cmd_q[7:0], rd_data_q};
					end else if (off < CW'(6 + ERR_LEN)) begin
						err_q <= {err_q[23:0], rd_data_q};
					end
				end
			end
			default: begin
			end
		endcase
		if (load_info) begin
			kind_q  <= KIND_INFO;
			opwd_q  <= pwd_q;
			ocmd_q  <= cmd_q;
			oerr_q  <= has_err ? err_q : 32'd0;
			obyte_q <= 8'd0;
			olast_q <= biz_none;
		end else if (load_data) begin
			kind_q  <= KIND_DATA;
			opwd_q  <= 32'd0;
			ocmd_q  <= 16'd0;
			oerr_q  <= 32'd0;
			obyte_q <= rd_data_q;
			olast_q <= data_last;
		end
	end

	assign res.valid            = ovalid_q;
	assign res.item_kind        = kind_q;
	assign res.frame_password   = opwd_q;
	assign res.frame_command    = ocmd_q;
	assign res.frame_error_code = oerr_q;
	assign res.data_byte        = obyte_q;
	assign res.last_of_frame    = olast_q;

	assign status.idle = state_q == ST_IDLE;
	assign status.full = count_q == CW'(STORE_DEPTH);

endmodule

@@ src/sync_length_checksum_deframer.sv @@
// Channel   Dir  Payload                                        Handshake
// rx        in   rx_byte                                        valid/ready
// res       out  item_kind, frame_password, frame_command,      valid/ready
//                frame_error_code, data_byte, last_of_frame
// cfg       in   cfg_index, cfg_wdata                           cfg_we
//
// A four-entry input queue takes bytes while the frame engine works; the engine
// reads the byte store through one registered port and waits for each read to land.
// A scan walks the stored bytes one by one; a good frame has its checks run, then
// yields one info item and one item for each data byte.
// Reset clears the store pointers at once; no clearing pass is needed.
// Results sit in an output register; a stalled sink holds the engine and, once
// the input queue is full, the rx channel as well.
module sync_length_checksum_deframer import slcd_pkg::*; #(
	parameter int SYNC_LEN    = DEF_SYNC_LEN,
	parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	slcd_byte_if.sink             rx,
	slcd_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	inq_head_t    inq;
	logic         pop;
	core_status_t status;

	slcd_inq u_inq (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.head   (inq),
		.pop    (pop)
	);

	slcd_core #(
		.SYNC_LEN    (SYNC_LEN),
		.STORE_DEPTH (STORE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.inq       (inq),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.res       (res),
		.status    (status)
	);

	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.item_kind == KIND_DATA |->
		res.frame_password == 32'd0 && res.frame_command == 16'd0 &&
		res.frame_error_code == 32'd0)
		else $error("data item carries frame fields");

	a_info_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.item_kind == KIND_INFO |-> res.data_byte == 8'd0)
		else $error("info item carries a data byte");

	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		status.idle |-> !status.full)
		else $error("store full while waiting for a byte");

endmodule

@@ tb/sv/tb_sync_length_checksum_deframer.sv @@
`timescale 1ns / 1ps

module tb_sync_length_checksum_deframer;
	import slcd_pkg::*;

	localparam int SYNC_N    = DEF_SYNC_LEN;
	localparam int DEPTH     = DEF_STORE_DEPTH;
	localparam int LINK_HDR  = SYNC_N + HDR_TAIL;
	localparam int SETTLE    = 2000;

	localparam int CORRUPT_NONE = 0;
	localparam int CORRUPT_HDR  = 1;
	localparam int CORRUPT_APP  = 2;

	typedef struct {
		logic        kind;
		logic [31:0] password;
		logic [15:0] command;
		logic [31:0] error_code;
		logic [7:0]  data;
		logic        last;
	} frame_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	slcd_byte_if rx_ch();
	slcd_res_if res_ch();

	sync_length_checksum_deframer dut (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch.sink), .res(res_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Shadow of the block: byte store, registers and the items still owed.
	logic [7:0]  link_store[$];
	logic [31:0] sync_reg = '0;
	logic [6:0]  min_len_reg = 7'(MIN_APP_RST);
	frame_item_t frames_due[$];
	int          n_fail = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;

	function automatic logic [7:0] sync_at(int j);
		return 8'(sync_reg >> (8 * (SYNC_N - 1 - j)));
	endfunction

	function automatic bit sync_hit(int pos, int n);
		for (int j = 0; j < n; j++)
			if (link_store[pos + j] != sync_at(j))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] twos_sum(int start, int n);
		logic [7:0] s;
		s = '0;
		for (int i = 0; i < n; i++)
			s += link_store[start + i];
		return 8'(~s + 8'd1);
	endfunction

	function automatic void drop_front(int n);
		for (int i = 0; i < n && link_store.size() > 0; i++)
			void'(link_store.pop_front());
	endfunction

	function automatic logic [31:0] word_at(int p);
		return {link_store[p], link_store[p+1], link_store[p+2], link_store[p+3]};
	endfunction

	function automatic void deframe_step(logic [7:0] b);
		int pos, keep, len, total, floor_len, nbiz;
		bit found;
		frame_item_t it;
		if (link_store.size() >= DEPTH)
			void'(link_store.pop_front());
		link_store = {link_store, b};
		forever begin
			found = 1'b0;
			for (pos = 0; pos + SYNC_N <= link_store.size(); pos++)
				if (sync_hit(pos, SYNC_N)) begin
					found = 1'b1;
					break;
				end
			if (!found) begin
				// Keep the longest tail that could still grow into a sync.
				keep = link_store.size();
				pos = link_store.size() >= SYNC_N ? link_store.size() - SYNC_N + 1 : 0;
				for (; pos < link_store.size(); pos++)
					if (sync_hit(pos, link_store.size() - pos)) begin
						keep = pos;
						break;
					end
				drop_front(keep);
				return;
			end
			drop_front(pos);
			if (link_store.size() < LINK_HDR)
				return;
			if (link_store[SYNC_N + 2] != twos_sum(0, SYNC_N + 2)) begin
				drop_front(1);
				continue;
			end
			len = {link_store[SYNC_N], link_store[SYNC_N + 1]};
			total = LINK_HDR + len;
			if (total > DEPTH || len > MAX_APP_LEN) begin
				drop_front(1);
				continue;
			end
			if (link_store.size() < total)
				return;
			floor_len = min_len_reg < APP_FIXED ? APP_FIXED : min_len_reg;
			if (len < floor_len) begin
				drop_front(total);
				continue;
			end
			if (link_store[LINK_HDR + len - 1] != twos_sum(LINK_HDR, len - 1)) begin
				drop_front(1);
				continue;
			end
			nbiz = (len - APP_FIXED >= ERR_LEN) ? len - APP_FIXED - ERR_LEN : 0;
			it.kind = KIND_INFO;
			it.password = word_at(LINK_HDR);
			it.command = {link_store[LINK_HDR + 4], link_store[LINK_HDR + 5]};
			it.error_code = (len - APP_FIXED >= ERR_LEN) ? word_at(LINK_HDR + 6) : '0;
			it.data = '0;
			it.last = (nbiz == 0);
			frames_due = {frames_due, it};
			for (int i = 0; i < nbiz && i + 1 < MAX_RESULTS; i++) begin
				it.kind = KIND_DATA;
				it.password = '0;
				it.command = '0;
				it.error_code = '0;
				it.data = link_store[LINK_HDR + 10 + i];
				it.last = (i + 1 == nbiz);
				frames_due = {frames_due, it};
			end
			drop_front(total);
			return;
		end
	endfunction

	always @(posedge clk) begin
		frame_item_t want;
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (frames_due.size() == 0) begin
				$error("result item with none expected");
				n_fail++;
			end else begin
				want = frames_due.pop_front();
				if (res_ch.item_kind !== want.kind) begin
					$error("item_kind exp %0h got %0h", want.kind, res_ch.item_kind);
					n_fail++;
				end
				if (res_ch.frame_password !== want.password) begin
					$error("frame_password exp %0h got %0h", want.password,
						res_ch.frame_password);
					n_fail++;
				end
				if (res_ch.frame_command !== want.command) begin
					$error("frame_command exp %0h got %0h", want.command,
						res_ch.frame_command);
					n_fail++;
				end
				if (res_ch.frame_error_code !== want.error_code) begin
					$error("frame_error_code exp %0h got %0h", want.error_code,
						res_ch.frame_error_code);
					n_fail++;
				end
				if (res_ch.data_byte !== want.data) begin
					$error("data_byte exp %0h got %0h", want.data, res_ch.data_byte);
					n_fail++;
				end
				if (res_ch.last_of_frame !== want.last) begin
					$error("last_of_frame exp %0h got %0h", want.last,
						res_ch.last_of_frame);
					n_fail++;
				end
			end
		end
	end

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		deframe_step(b);
	endtask

	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SYNC_PATTERN)
			sync_reg = val;
		else
			min_len_reg = val[6:0];
	endtask

	// Sends one frame; the length field may be forced to odd values.
	task automatic send_frame(int len, int corrupt, logic [15:0] len_field = 16'hFFFF,
		int fill = -1);
		logic [7:0] fr[$];
		logic [7:0] s;
		fr = {};
		for (int j = 0; j < SYNC_N; j++)
			fr = {fr, sync_at(j)};
		if (len_field == 16'hFFFF)
			len_field = 16'(len);
		fr = {fr, len_field[15:8]};
		fr = {fr, len_field[7:0]};
		s = '0;
		foreach (fr[i]) s += fr[i];
		fr = {fr, 8'(~s + 8'd1) ^ (corrupt == CORRUPT_HDR ? 8'h01 : 8'h00)};
		s = '0;
		for (int i = 0; i < len - 1; i++) begin
			fr = {fr, (fill < 0 ? 8'($urandom) : 8'(fill))};
			s += fr[$];
		end
		if (len > 0)
			fr = {fr, 8'(~s + 8'd1) ^ (corrupt == CORRUPT_APP ? 8'h80 : 8'h00)};
		foreach (fr[i]) send_byte(fr[i]);
	endtask

	task automatic test_directed();
		send_frame(11, CORRUPT_NONE);
		send_frame(11, CORRUPT_NONE, 16'hFFFF, 8'hFF);
		write_reg(REG_SYNC_PATTERN, 32'hFFFF_A55A);
		write_reg(REG_MIN_APP_LEN, 7'd7);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(7, CORRUPT_NONE, 16'hFFFF, 8'h00);
		send_frame(10, CORRUPT_NONE);
		send_frame(12, CORRUPT_HDR);
		send_frame(12, CORRUPT_APP);
		send_frame(12, CORRUPT_NONE);
		send_frame(0, CORRUPT_NONE, 16'hFFFF);
		send_frame(6, CORRUPT_NONE);
		send_frame(2, CORRUPT_NONE, 16'h0100);
		send_byte(8'hA5);
		send_frame(59, CORRUPT_NONE);
		write_reg(REG_MIN_APP_LEN, 7'd64);
		send_frame(20, CORRUPT_NONE);
		write_reg(REG_MIN_APP_LEN, 7'd127);
		send_frame(8, CORRUPT_NONE);
		write_reg(REG_MIN_APP_LEN, 7'd0);
		send_frame(7, CORRUPT_NONE);
		send_frame(3, CORRUPT_NONE, 16'd60);
	endtask

	task automatic test_random_phase(int idle, int stall, int nbytes, bit hold_off);
		int sent, len, pick;
		write_reg(REG_SYNC_PATTERN, $urandom);
		write_reg(REG_MIN_APP_LEN, $urandom_range(7, 16));
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < nbytes) begin
			pick = $urandom_range(99);
			len = $urandom_range(9) == 0 ? $urandom_range(20, 59) : $urandom_range(5, 20);
			if (pick < 70)
				send_frame(len, CORRUPT_NONE);
			else if (pick < 80)
				send_frame(len, $urandom_range(1, 2));
			else
				for (int i = $urandom_range(1, 6); i > 0; i--)
					send_byte(pick < 90 ? 8'($urandom) : sync_at($urandom_range(SYNC_N - 1)));
			sent += pick < 80 ? LINK_HDR + len : 3;
			if (hold_off && sent > nbytes / 2) begin
				hold_off = 1'b0;
				drain();
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(0, 0, 20, 1'b1);
		test_random_phase(73, 0, 18, 1'b0);
		test_random_phase(0, 73, 18, 1'b0);
		test_random_phase(23, 23, 18, 1'b0);
		drain();
		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
